>>> rtl/lfpd_pkg.sv
// Shared constants, register indexes and types of the line-follow PD controller.
`default_nettype none

package lfpd_pkg;

   localparam int SAMPLE_BITS_DEF  = 10;
   localparam int ELAPSED_BITS_DEF = 24;

   localparam int ERR_BITS    = 12;
   localparam int QUOT_BITS   = 32;
   localparam int DRIVE_BITS  = 32;
   localparam int SPEED_BITS  = 9;
   localparam int GAIN_BITS   = 8;
   localparam int DARK_BITS   = 10;
   localparam int SPEED_LIMIT = 255;
   localparam int US_PER_SEC  = 1000000;
   localparam int GAIN_SCALE  = 10;

   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 10;

   localparam logic [CSR_IDX_BITS-1:0] CSR_PROP_GAIN    = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DERIV_GAIN   = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_OVERALL_GAIN = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LEFT_DARK    = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RIGHT_DARK   = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BASE_SPEED   = 3'd5;

   // status of a serial unit back to the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } unit_sts_type;

endpackage

`default_nettype wire

>>> rtl/lfpd_if.sv
// Request and response channel interfaces of the line-follow PD controller.
`default_nettype none

interface lfpd_req_if #(
   parameter int SAMPLE_BITS  = lfpd_pkg::SAMPLE_BITS_DEF,
   parameter int ELAPSED_BITS = lfpd_pkg::ELAPSED_BITS_DEF
);
   logic                    valid;
   logic                    ready;
   logic [SAMPLE_BITS-1:0]  left_sample;
   logic [SAMPLE_BITS-1:0]  right_sample;
   logic [ELAPSED_BITS-1:0] elapsed_us;

   modport source (output valid, left_sample, right_sample, elapsed_us, input ready);
   modport sink   (input valid, left_sample, right_sample, elapsed_us, output ready);
endinterface

interface lfpd_rsp_if;
   logic                                     valid;
   logic                                     ready;
   logic signed [lfpd_pkg::ERR_BITS-1:0]     tape_error;
   logic signed [lfpd_pkg::DRIVE_BITS-1:0]   drive;
   logic signed [lfpd_pkg::SPEED_BITS-1:0]   left_speed;
   logic signed [lfpd_pkg::SPEED_BITS-1:0]   right_speed;

   modport source (output valid, tape_error, drive, left_speed, right_speed, input ready);
   modport sink   (input valid, tape_error, drive, left_speed, right_speed, output ready);
endinterface

`default_nettype wire

>>> rtl/lfpd_tape_error.sv
// Tape error former with last-error and last-side state.
`default_nettype none

module lfpd_tape_error #(
   parameter int SAMPLE_BITS = lfpd_pkg::SAMPLE_BITS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 load,
   input  wire logic [SAMPLE_BITS-1:0]               left_sample,
   input  wire logic [SAMPLE_BITS-1:0]               right_sample,
   input  wire logic [lfpd_pkg::DARK_BITS-1:0]       left_dark_level,
   input  wire logic [lfpd_pkg::DARK_BITS-1:0]       right_dark_level,
   output logic signed [lfpd_pkg::ERR_BITS-1:0]      tape_error,
   output logic [lfpd_pkg::ERR_BITS-1:0]             delta_mag,
   output logic                                      delta_neg
);
   import lfpd_pkg::*;

   localparam int VAL_BITS = (SAMPLE_BITS > DARK_BITS) ? SAMPLE_BITS : DARK_BITS;
   localparam int EXT_BITS = VAL_BITS + 2;

   logic signed [EXT_BITS-1:0] ls_x, rs_x, ld_x, rd_x;
   logic signed [EXT_BITS-1:0] ldev, rdev, dsum, err_full;
   logic                       ldark, rdark;
   logic signed [ERR_BITS-1:0] err_now;
   logic signed [ERR_BITS:0]   delta;
   logic [ERR_BITS:0]          delta_abs;

   logic signed [ERR_BITS-1:0] last_error_ff;
   logic                       last_side_left_ff, last_side_left_in;
   logic [ERR_BITS-1:0]        delta_mag_ff;
   logic                       delta_neg_ff;

   always_comb begin
      ls_x  = signed'(EXT_BITS'(left_sample));
      rs_x  = signed'(EXT_BITS'(right_sample));
      ld_x  = signed'(EXT_BITS'(left_dark_level));
      rd_x  = signed'(EXT_BITS'(right_dark_level));
      ldark = ls_x < ld_x;
      rdark = rs_x < rd_x;
      rdev  = rd_x - rs_x;
      ldev  = ld_x - ls_x;
      dsum  = rdev + ldev;
      last_side_left_in = last_side_left_ff;
      if (rdark && !ldark) begin
         err_full          = rdev;
         last_side_left_in = 1'b0;
      end else if (!rdark && ldark) begin
         err_full          = -ldev;
         last_side_left_in = 1'b1;
      end else if (rdark && ldark) begin
         err_full = last_side_left_ff ? -dsum : dsum;
      end else begin
         err_full = '0;
      end
      // keep low bits only: wraps when samples are wide
      err_now   = err_full[ERR_BITS-1:0];
      delta     = {err_now[ERR_BITS-1], err_now} - {last_error_ff[ERR_BITS-1], last_error_ff};
      delta_abs = delta[ERR_BITS] ? (ERR_BITS+1)'(-delta) : delta;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_error_ff     <= '0;
         last_side_left_ff <= 1'b0;
      end else if (load) begin
         last_error_ff     <= err_now;
         last_side_left_ff <= last_side_left_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         delta_mag_ff <= delta_abs[ERR_BITS-1:0];
         delta_neg_ff <= delta[ERR_BITS];
      end
   end

   assign tape_error = last_error_ff;
   assign delta_mag  = delta_mag_ff;
   assign delta_neg  = delta_neg_ff;

endmodule

`default_nettype wire

>>> rtl/lfpd_serial_div.sv
// Bit-serial restoring divider for the derivative quotient.
`default_nettype none

module lfpd_serial_div #(
   parameter int DEN_BITS = lfpd_pkg::ELAPSED_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic [lfpd_pkg::ERR_BITS-1:0]   delta_mag,
   input  wire logic [DEN_BITS-1:0]             den,
   output logic [lfpd_pkg::QUOT_BITS-1:0]       quot,
   output lfpd_pkg::unit_sts_type               sts
);
   import lfpd_pkg::*;

   localparam int CNT_BITS = $clog2(QUOT_BITS);
   localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(QUOT_BITS - 1);

   logic [QUOT_BITS-1:0] num_ff, num_in;
   logic [DEN_BITS-1:0]  rem_ff, rem_in;
   logic [DEN_BITS:0]    trial, diff;
   logic                 ge;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic                 busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      trial   = {rem_ff, num_ff[QUOT_BITS-1]};
      diff    = trial - {1'b0, den};
      ge      = trial >= {1'b0, den};
      num_in  = num_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         // scale to microseconds per second before dividing
         num_in  = QUOT_BITS'(QUOT_BITS'(delta_mag) * QUOT_BITS'(US_PER_SEC));
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // numerator shifts out at the top, quotient bits enter at the bottom
         num_in = {num_ff[QUOT_BITS-2:0], ge};
         rem_in = ge ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
   end

   // no time elapsed: derivative is zero
   assign quot     = (den == '0) ? '0 : num_ff;
   assign sts.busy = busy_ff;
   assign sts.done = done_ff;

endmodule

`default_nettype wire

>>> rtl/lfpd_drive_unit.sv
// Serial gain multiplies, divide by ten, drive saturation and motor speeds.
`default_nettype none

module lfpd_drive_unit (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   input  wire logic signed [lfpd_pkg::ERR_BITS-1:0]  tape_error,
   input  wire logic [lfpd_pkg::QUOT_BITS-1:0]        quot,
   input  wire logic                                  deriv_neg,
   input  wire logic [lfpd_pkg::GAIN_BITS-1:0]        prop_gain,
   input  wire logic [lfpd_pkg::GAIN_BITS-1:0]        deriv_gain,
   input  wire logic [lfpd_pkg::GAIN_BITS-1:0]        overall_gain,
   input  wire logic [lfpd_pkg::GAIN_BITS-1:0]        base_speed,
   output logic signed [lfpd_pkg::DRIVE_BITS-1:0]     drive,
   output logic signed [lfpd_pkg::SPEED_BITS-1:0]     left_speed,
   output logic signed [lfpd_pkg::SPEED_BITS-1:0]     right_speed,
   output lfpd_pkg::unit_sts_type                     sts
);
   import lfpd_pkg::*;

   localparam int PACC_BITS = ERR_BITS + GAIN_BITS;
   localparam int DACC_BITS = QUOT_BITS + GAIN_BITS;
   localparam int SUM_BITS  = DACC_BITS + 2;
   localparam int SMAG_BITS = DACC_BITS + 1;
   localparam int GACC_BITS = SMAG_BITS + GAIN_BITS;
   localparam int DV_BITS   = GACC_BITS + (GACC_BITS % 2);
   localparam int DIV_STEPS = DV_BITS / 2;
   localparam int CNT_BITS  = $clog2(DIV_STEPS);
   localparam int REM_BITS  = $clog2(GAIN_SCALE);
   localparam int SPD_W     = DRIVE_BITS + 2;

   localparam logic [CNT_BITS-1:0] MUL_LAST = CNT_BITS'(GAIN_BITS - 1);
   localparam logic [CNT_BITS-1:0] DIV_LAST = CNT_BITS'(DIV_STEPS - 1);
   localparam logic [REM_BITS:0]   SCALE    = (REM_BITS+1)'(GAIN_SCALE);

   localparam logic signed [DRIVE_BITS-1:0] DRIVE_MAX = {1'b0, {(DRIVE_BITS-1){1'b1}}};
   localparam logic signed [DRIVE_BITS-1:0] DRIVE_MIN = {1'b1, {(DRIVE_BITS-1){1'b0}}};
   localparam logic signed [SPD_W-1:0]      LIM_P     = SPD_W'(SPEED_LIMIT);
   localparam logic signed [SPD_W-1:0]      LIM_N     = -LIM_P;

   localparam logic [2:0] D_IDLE  = 3'd0;
   localparam logic [2:0] D_MUL1  = 3'd1;
   localparam logic [2:0] D_SUM   = 3'd2;
   localparam logic [2:0] D_MUL2  = 3'd3;
   localparam logic [2:0] D_DIV10 = 3'd4;
   localparam logic [2:0] D_SAT   = 3'd5;
   localparam logic [2:0] D_SPEED = 3'd6;

   // trunc(v/2) then clamp to the motor range
   function automatic logic signed [SPEED_BITS-1:0] half_clamp(
      input logic signed [SPD_W-1:0] v
   );
      logic signed [SPD_W-1:0] h;
      logic signed [SPD_W-1:0] c;
      h = signed'(v + SPD_W'(v[SPD_W-1])) >>> 1;
      if (h > LIM_P) c = LIM_P;
      else if (h < LIM_N) c = LIM_N;
      else c = h;
      return c[SPEED_BITS-1:0];
   endfunction

   logic [2:0]                  state_ff, state_in;
   logic [CNT_BITS-1:0]         cnt_ff, cnt_in;
   logic                        done_ff, done_in;

   logic [ERR_BITS-1:0]         emag_ff, emag_in;
   logic                        eneg_ff, eneg_in;
   logic [GAIN_BITS-1:0]        pgain_ff, pgain_in, dgain_ff, dgain_in, ggain_ff, ggain_in;
   logic [PACC_BITS-1:0]        pacc_ff, pacc_in;
   logic [DACC_BITS-1:0]        dacc_ff, dacc_in;
   logic [SMAG_BITS-1:0]        smag_ff, smag_in;
   logic                        sneg_ff, sneg_in;
   logic [GACC_BITS-1:0]        gacc_ff, gacc_in;
   logic [DV_BITS-1:0]          dv_ff, dv_in;
   logic [REM_BITS-1:0]         rem_ff, rem_in;
   logic signed [DRIVE_BITS-1:0] drive_ff, drive_in;
   logic signed [SPEED_BITS-1:0] lsp_ff, lsp_in, rsp_ff, rsp_in;

   logic signed [SUM_BITS-1:0]  sp, sd, ssum;
   logic [SUM_BITS-1:0]         sabs;
   logic [REM_BITS:0]           t1, t2;
   logic [REM_BITS-1:0]         r1, r2;
   logic                        g1, g2;
   logic                        pos_over, neg_over;
   logic signed [SPD_W-1:0]     base2, dx, lv, rv;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      emag_in  = emag_ff;
      eneg_in  = eneg_ff;
      pgain_in = pgain_ff;
      dgain_in = dgain_ff;
      ggain_in = ggain_ff;
      pacc_in  = pacc_ff;
      dacc_in  = dacc_ff;
      smag_in  = smag_ff;
      sneg_in  = sneg_ff;
      gacc_in  = gacc_ff;
      dv_in    = dv_ff;
      rem_in   = rem_ff;
      drive_in = drive_ff;
      lsp_in   = lsp_ff;
      rsp_in   = rsp_ff;

      // sign and magnitude of the PD sum
      sp   = signed'(SUM_BITS'(pacc_ff));
      sd   = signed'(SUM_BITS'(dacc_ff));
      if (eneg_ff) sp = -sp;
      if (deriv_neg) sd = -sd;
      ssum = sp + sd;
      sabs = ssum[SUM_BITS-1] ? SUM_BITS'(-ssum) : ssum;

      // two radix-2 steps of the divide by ten
      t1 = {rem_ff, dv_ff[DV_BITS-1]};
      g1 = t1 >= SCALE;
      r1 = g1 ? REM_BITS'(t1 - SCALE) : t1[REM_BITS-1:0];
      t2 = {r1, dv_ff[DV_BITS-2]};
      g2 = t2 >= SCALE;
      r2 = g2 ? REM_BITS'(t2 - SCALE) : t2[REM_BITS-1:0];

      pos_over = |dv_ff[DV_BITS-1:DRIVE_BITS-1];
      neg_over = (|dv_ff[DV_BITS-1:DRIVE_BITS]) ||
                 (dv_ff[DRIVE_BITS-1] && (|dv_ff[DRIVE_BITS-2:0]));

      base2 = signed'(SPD_W'({base_speed, 1'b0}));
      dx    = SPD_W'(drive_ff);
      lv    = base2 - dx;
      rv    = base2 + dx;

      case (state_ff)
         D_IDLE: begin
            if (start) begin
               eneg_in  = tape_error[ERR_BITS-1];
               emag_in  = tape_error[ERR_BITS-1] ? ERR_BITS'(-tape_error) : tape_error;
               pgain_in = prop_gain;
               dgain_in = deriv_gain;
               pacc_in  = '0;
               dacc_in  = '0;
               cnt_in   = '0;
               state_in = D_MUL1;
            end
         end
         D_MUL1: begin
            // MSB-first shift-add, both gain products together
            pacc_in  = {pacc_ff[PACC_BITS-2:0], 1'b0} +
                       (pgain_ff[GAIN_BITS-1] ? PACC_BITS'(emag_ff) : '0);
            dacc_in  = {dacc_ff[DACC_BITS-2:0], 1'b0} +
                       (dgain_ff[GAIN_BITS-1] ? DACC_BITS'(quot) : '0);
            pgain_in = pgain_ff << 1;
            dgain_in = dgain_ff << 1;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == MUL_LAST) state_in = D_SUM;
         end
         D_SUM: begin
            sneg_in  = ssum[SUM_BITS-1];
            smag_in  = sabs[SMAG_BITS-1:0];
            ggain_in = overall_gain;
            gacc_in  = '0;
            cnt_in   = '0;
            state_in = D_MUL2;
         end
         D_MUL2: begin
            gacc_in  = {gacc_ff[GACC_BITS-2:0], 1'b0} +
                       (ggain_ff[GAIN_BITS-1] ? GACC_BITS'(smag_ff) : '0);
            ggain_in = ggain_ff << 1;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == MUL_LAST) begin
               dv_in    = DV_BITS'(gacc_in);
               rem_in   = '0;
               cnt_in   = '0;
               state_in = D_DIV10;
            end
         end
         D_DIV10: begin
            dv_in  = {dv_ff[DV_BITS-3:0], g1, g2};
            rem_in = r2;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) state_in = D_SAT;
         end
         D_SAT: begin
            if (sneg_ff) drive_in = neg_over ? DRIVE_MIN : ~dv_ff[DRIVE_BITS-1:0] + 1'b1;
            else         drive_in = pos_over ? DRIVE_MAX : dv_ff[DRIVE_BITS-1:0];
            state_in = D_SPEED;
         end
         D_SPEED: begin
            lsp_in   = half_clamp(lv);
            rsp_in   = half_clamp(rv);
            done_in  = 1'b1;
            state_in = D_IDLE;
         end
         default: begin
            state_in = D_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      emag_ff  <= emag_in;
      eneg_ff  <= eneg_in;
      pgain_ff <= pgain_in;
      dgain_ff <= dgain_in;
      ggain_ff <= ggain_in;
      pacc_ff  <= pacc_in;
      dacc_ff  <= dacc_in;
      smag_ff  <= smag_in;
      sneg_ff  <= sneg_in;
      gacc_ff  <= gacc_in;
      dv_ff    <= dv_in;
      rem_ff   <= rem_in;
      drive_ff <= drive_in;
      lsp_ff   <= lsp_in;
      rsp_ff   <= rsp_in;
   end

   assign drive       = drive_ff;
   assign left_speed  = lsp_ff;
   assign right_speed = rsp_ff;
   assign sts.busy    = state_ff != D_IDLE;
   assign sts.done    = done_ff;

endmodule

`default_nettype wire

>>> rtl/line_follow_pd_controller.sv
// Line-follow PD controller top level: sequencer, config registers and response register.
//
// Takes one transaction of two reflectance samples and the microseconds since the
// previous pair, and returns one transaction with the signed tape error, the saturated
// PD drive and the two saturated motor commands. Work is one transaction at a time: the
// bit-serial divider forms the derivative (one quotient bit a cycle), then the drive
// unit runs the shift-add gain multiplies (one gain bit a cycle) with the PD sum
// between them, the divide by ten (two bits a cycle), saturation and the motor speeds.
// A finished response waits in its own register, so the next request is taken while
// it is still unread. Configuration writes are only legal while the block is idle.
`default_nettype none

module line_follow_pd_controller #(
   parameter int SAMPLE_BITS  = lfpd_pkg::SAMPLE_BITS_DEF,
   parameter int ELAPSED_BITS = lfpd_pkg::ELAPSED_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   lfpd_req_if.sink                                 req_if,
   lfpd_rsp_if.source                               rsp_if,
   input  wire logic                                csr_wr_en,
   input  wire logic [lfpd_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  wire logic [lfpd_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import lfpd_pkg::*;

   // sequencer states
   localparam logic [2:0] T_IDLE  = 3'd0;  // ready for a request
   localparam logic [2:0] T_START = 3'd1;  // error registered, kick divider
   localparam logic [2:0] T_DIV   = 3'd2;  // derivative divide running
   localparam logic [2:0] T_DRV   = 3'd3;  // gains, scale, saturation
   localparam logic [2:0] T_HOLD  = 3'd4;  // waiting for response register

   logic [2:0] state_ff, state_in;

   // configuration
   logic [GAIN_BITS-1:0] prop_gain_ff, deriv_gain_ff, overall_gain_ff, base_speed_ff;
   logic [DARK_BITS-1:0] left_dark_ff, right_dark_ff;

   logic [ELAPSED_BITS-1:0] elapsed_ff;

   logic                        accept;
   logic                        out_free;
   logic                        div_start, drv_start;
   unit_sts_type                div_sts, drv_sts;
   logic signed [ERR_BITS-1:0]  tape_error;
   logic [ERR_BITS-1:0]         delta_mag;
   logic                        delta_neg;
   logic [QUOT_BITS-1:0]        quot;
   logic signed [DRIVE_BITS-1:0] drive;
   logic signed [SPEED_BITS-1:0] left_speed, right_speed;

   // response register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [ERR_BITS-1:0]   rsp_err_ff;
   logic signed [DRIVE_BITS-1:0] rsp_drive_ff;
   logic signed [SPEED_BITS-1:0] rsp_lsp_ff, rsp_rsp_ff;

   assign req_if.ready = state_ff == T_IDLE;
   assign accept       = req_if.valid && req_if.ready;
   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   assign div_start    = state_ff == T_START;
   assign drv_start    = (state_ff == T_DIV) && div_sts.done;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         T_IDLE:  if (req_if.valid) state_in = T_START;
         T_START: state_in = T_DIV;
         T_DIV:   if (div_sts.done) state_in = T_DRV;
         T_DRV:   if (drv_sts.done) state_in = T_HOLD;
         T_HOLD:  if (out_free) state_in = T_IDLE;
         default: state_in = T_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if ((state_ff == T_HOLD) && out_free) rsp_valid_in = 1'b1;
      else if (rsp_if.ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // register writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff    <= '0;
         deriv_gain_ff   <= '0;
         overall_gain_ff <= '0;
         left_dark_ff    <= '0;
         right_dark_ff   <= '0;
         base_speed_ff   <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_PROP_GAIN:    prop_gain_ff    <= csr_wdata[GAIN_BITS-1:0];
            CSR_DERIV_GAIN:   deriv_gain_ff   <= csr_wdata[GAIN_BITS-1:0];
            CSR_OVERALL_GAIN: overall_gain_ff <= csr_wdata[GAIN_BITS-1:0];
            CSR_LEFT_DARK:    left_dark_ff    <= csr_wdata[DARK_BITS-1:0];
            CSR_RIGHT_DARK:   right_dark_ff   <= csr_wdata[DARK_BITS-1:0];
            CSR_BASE_SPEED:   base_speed_ff   <= csr_wdata[GAIN_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) elapsed_ff <= req_if.elapsed_us;
      if ((state_ff == T_HOLD) && out_free) begin
         rsp_err_ff   <= tape_error;
         rsp_drive_ff <= drive;
         rsp_lsp_ff   <= left_speed;
         rsp_rsp_ff   <= right_speed;
      end
   end

   lfpd_tape_error #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_error (
      .clock            (clock),
      .reset            (reset),
      .load             (accept),
      .left_sample      (req_if.left_sample),
      .right_sample     (req_if.right_sample),
      .left_dark_level  (left_dark_ff),
      .right_dark_level (right_dark_ff),
      .tape_error       (tape_error),
      .delta_mag        (delta_mag),
      .delta_neg        (delta_neg)
   );

   lfpd_serial_div #(
      .DEN_BITS (ELAPSED_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .delta_mag (delta_mag),
      .den       (elapsed_ff),
      .quot      (quot),
      .sts       (div_sts)
   );

   lfpd_drive_unit u_drive (
      .clock        (clock),
      .reset        (reset),
      .start        (drv_start),
      .tape_error   (tape_error),
      .quot         (quot),
      .deriv_neg    (delta_neg),
      .prop_gain    (prop_gain_ff),
      .deriv_gain   (deriv_gain_ff),
      .overall_gain (overall_gain_ff),
      .base_speed   (base_speed_ff),
      .drive        (drive),
      .left_speed   (left_speed),
      .right_speed  (right_speed),
      .sts          (drv_sts)
   );

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.tape_error  = rsp_err_ff;
   assign rsp_if.drive       = rsp_drive_ff;
   assign rsp_if.left_speed  = rsp_lsp_ff;
   assign rsp_if.right_speed = rsp_rsp_ff;

   // both serial units are quiet whenever a request can be taken
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == T_IDLE) |-> (!div_sts.busy && !drv_sts.busy))
      else $error("serial unit busy while sequencer idle");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_sts.done |-> (state_ff == T_DIV))
      else $error("divider finished outside divide phase");

   a_drv_done_in_drv: assert property (@(posedge clock) disable iff (reset)
      drv_sts.done |-> (state_ff == T_DRV))
      else $error("drive unit finished outside drive phase");

   a_hold_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == T_HOLD) && out_free) |=> rsp_valid_ff)
      else $error("finished transaction not presented");

endmodule

`default_nettype wire

>>> bench/lfpd_steer_checker.sv
// Response checker for the line-follow PD controller: predicts each response and compares it.
module lfpd_steer_checker (
   input  logic                                clock,
   input  logic                                reset,
   lfpd_req_if                                 req_if,
   lfpd_rsp_if                                 rsp_if,
   input  logic                                csr_wr_en,
   input  logic [lfpd_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [lfpd_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output int                                  fail_count,
   output int                                  pending
);
   timeunit 1ns;
   timeprecision 1ps;

   import lfpd_pkg::*;

   localparam longint DRIVE_MAX = (64'sd1 <<< (DRIVE_BITS - 1)) - 64'sd1;
   localparam longint DRIVE_MIN = -(64'sd1 <<< (DRIVE_BITS - 1));

   typedef struct packed {
      logic signed [ERR_BITS-1:0]   tape_error;
      logic signed [DRIVE_BITS-1:0] drive;
      logic signed [SPEED_BITS-1:0] left_speed;
      logic signed [SPEED_BITS-1:0] right_speed;
   } steer_type;

   logic [GAIN_BITS-1:0]       prop_gain;
   logic [GAIN_BITS-1:0]       deriv_gain;
   logic [GAIN_BITS-1:0]       overall_gain;
   logic [GAIN_BITS-1:0]       base_speed;
   logic [DARK_BITS-1:0]       left_dark;
   logic [DARK_BITS-1:0]       right_dark;
   logic signed [ERR_BITS-1:0] last_tape_error;
   logic                       side_left;

   steer_type steer_q[$];
   int        errors = 0;

   function automatic longint clamp(input longint v, input longint lo, input longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // Works out the response to one sample pair and advances the tracking state.
   function automatic steer_type compute_steering(input logic [SAMPLE_BITS_DEF-1:0] l_smp,
                                                  input logic [SAMPLE_BITS_DEF-1:0] r_smp,
                                                  input logic [ELAPSED_BITS_DEF-1:0] el);
      longint ls, rs, ld, rd, pg, dg, og, bs, el_l, pe, e;
      longint err, deriv, drv, lsp, rsp_v;
      logic                       l_dark, r_dark;
      logic signed [ERR_BITS-1:0] e_wrapped;
      steer_type                  s;
      ls = l_smp;  rs = r_smp;  ld = left_dark;  rd = right_dark;
      pg = prop_gain;  dg = deriv_gain;  og = overall_gain;  bs = base_speed;
      el_l = el;  pe = last_tape_error;
      l_dark = ls < ld;
      r_dark = rs < rd;
      if (r_dark && !l_dark) begin
         side_left = 1'b0;
         err = rd - rs;
      end else if (l_dark && !r_dark) begin
         side_left = 1'b1;
         err = ls - ld;
      end else if (l_dark && r_dark) begin
         // both on tape: sign taken from the side last seen alone
         err = side_left ? -((rd - rs) + (ld - ls)) : ((rd - rs) + (ld - ls));
      end else begin
         err = 0;
      end
      e_wrapped = err[ERR_BITS-1:0];
      e = e_wrapped;
      deriv = 0;
      if (el_l != 0)
         deriv = (e - pe) * US_PER_SEC / el_l;
      drv = og * (pg * e + dg * deriv) / GAIN_SCALE;
      drv = clamp(drv, DRIVE_MIN, DRIVE_MAX);
      lsp = clamp((2 * bs - drv) / 2, -SPEED_LIMIT, SPEED_LIMIT);
      rsp_v = clamp((2 * bs + drv) / 2, -SPEED_LIMIT, SPEED_LIMIT);
      last_tape_error = e_wrapped;
      s.tape_error  = e_wrapped;
      s.drive       = drv[DRIVE_BITS-1:0];
      s.left_speed  = lsp[SPEED_BITS-1:0];
      s.right_speed = rsp_v[SPEED_BITS-1:0];
      return s;
   endfunction

   function automatic void check_field(input string name, input longint want_v,
                                       input longint got_v);
      if (want_v != got_v) begin
         $display("%t %s mismatch: expected %0d, actual %0d", $time, name, want_v, got_v);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      steer_type want;
      if (reset) begin
         prop_gain       = '0;
         deriv_gain      = '0;
         overall_gain    = '0;
         base_speed      = '0;
         left_dark       = '0;
         right_dark      = '0;
         last_tape_error = '0;
         side_left       = 1'b0;
         steer_q.delete();
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (steer_q.size() == 0) begin
               $display("%t unexpected response: expected none, actual %0d/%0d/%0d/%0d",
                        $time, rsp_if.tape_error, rsp_if.drive, rsp_if.left_speed,
                        rsp_if.right_speed);
               errors++;
            end else begin
               want = steer_q.pop_front();
               check_field("tape_error", want.tape_error, rsp_if.tape_error);
               check_field("drive", want.drive, rsp_if.drive);
               check_field("left_speed", want.left_speed, rsp_if.left_speed);
               check_field("right_speed", want.right_speed, rsp_if.right_speed);
            end
         end
         if (req_if.valid && req_if.ready)
            steer_q.push_back(compute_steering(req_if.left_sample, req_if.right_sample,
                                               req_if.elapsed_us));
         if (csr_wr_en) begin
            case (csr_index)
               CSR_PROP_GAIN:    prop_gain    = csr_wdata[GAIN_BITS-1:0];
               CSR_DERIV_GAIN:   deriv_gain   = csr_wdata[GAIN_BITS-1:0];
               CSR_OVERALL_GAIN: overall_gain = csr_wdata[GAIN_BITS-1:0];
               CSR_LEFT_DARK:    left_dark    = csr_wdata[DARK_BITS-1:0];
               CSR_RIGHT_DARK:   right_dark   = csr_wdata[DARK_BITS-1:0];
               CSR_BASE_SPEED:   base_speed   = csr_wdata[GAIN_BITS-1:0];
               default: ;
            endcase
         end
      end
      fail_count <= errors;
      pending    <= steer_q.size();
   end

endmodule

>>> bench/line_follow_pd_controller_tb.sv
// Top of the line-follow PD controller testbench: clock, reset, stimulus and verdict.
module line_follow_pd_controller_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lfpd_pkg::*;

   // idle-cycle budget for the watchdog; some phases stall or idle at 77%
   localparam int WATCHDOG_LIMIT  = 5000;
   localparam int TAIL_CYCLES     = 120;
   localparam int RANDOM_PHASES   = 8;
   localparam int ITEMS_PER_PHASE = 85;

   // indexes past the last register; writes to them must be dropped
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE_HI = 3'd7;

   localparam logic [SAMPLE_BITS_DEF-1:0]  SAMPLE_MAX  = '1;
   localparam logic [ELAPSED_BITS_DEF-1:0] ELAPSED_MAX = '1;

   logic                     clock     = 1'b0;
   logic                     reset     = 1'b1;
   logic                     csr_wr_en = 1'b0;
   logic [CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   int send_idle_pct  = 0;   // chance per cycle that the sender holds back
   int recv_stall_pct = 0;   // chance per cycle that the receiver drops ready
   int fail_count;
   int pending;

   lfpd_req_if req_if ();
   lfpd_rsp_if rsp_if ();

   line_follow_pd_controller dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   lfpd_steer_checker chk (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .rsp_if     (rsp_if),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver: ready redrawn every edge, so stalls land on every phase of the work.
   always @(posedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Watchdog: ends the run after too many cycles with no transaction on either side.
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("line_follow_pd_controller_tb: FAIL");
      $finish;
   end

   // One register write; the caller drops the enable after the last one.
   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // Full register set, plus junk at the spare indexes which must change nothing.
   task automatic configure(input logic [CSR_DATA_BITS-1:0] pg, dg, og, ld, rd, bs);
      write_reg(CSR_PROP_GAIN, pg);
      write_reg(CSR_DERIV_GAIN, dg);
      write_reg(CSR_OVERALL_GAIN, og);
      write_reg(CSR_LEFT_DARK, ld);
      write_reg(CSR_RIGHT_DARK, rd);
      write_reg(CSR_BASE_SPEED, bs);
      write_reg(CSR_SPARE_LO, CSR_DATA_BITS'($urandom_range(1023)));
      write_reg(CSR_SPARE_HI, CSR_DATA_BITS'($urandom_range(1023)));
      csr_wr_en <= 1'b0;
   endtask

   // Offers one transaction and returns at the edge it is taken. Valid is not
   // dropped here, so back-to-back transactions need no low cycle between them.
   task automatic send_sample(input logic [SAMPLE_BITS_DEF-1:0]  l_smp,
                              input logic [SAMPLE_BITS_DEF-1:0]  r_smp,
                              input logic [ELAPSED_BITS_DEF-1:0] el);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid        <= 1'b0;
         // junk on the payload while idle; the block must ignore it
         req_if.left_sample  <= SAMPLE_BITS_DEF'($urandom);
         req_if.right_sample <= SAMPLE_BITS_DEF'($urandom);
         req_if.elapsed_us   <= ELAPSED_BITS_DEF'($urandom);
         @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.left_sample  <= l_smp;
      req_if.right_sample <= r_smp;
      req_if.elapsed_us   <= el;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   // Stops sending and waits until every expected response has come back.
   // The first edge lets the checker count the transaction just taken.
   task automatic settle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // Half the time near the dark level, where the error rule changes case;
   // otherwise the rails or anything at all.
   function automatic logic [SAMPLE_BITS_DEF-1:0] pick_sample(
         input logic [DARK_BITS-1:0] level);
      int v;
      case ($urandom_range(3))
         0: v = $urandom_range(1023);
         1: v = $urandom_range(1) ? 1023 : 0;
         default: begin
            v = level;
            v = v + int'($urandom_range(80)) - 40;
         end
      endcase
      if (v < 0) v = 0;
      if (v > 1023) v = 1023;
      return SAMPLE_BITS_DEF'(v);
   endfunction

   // Zero and tiny intervals stress the derivative; the ~50 ms case is the usual one.
   function automatic logic [ELAPSED_BITS_DEF-1:0] pick_elapsed();
      case ($urandom_range(7))
         0: return '0;
         1: return ELAPSED_BITS_DEF'(1);
         2: return ELAPSED_MAX;
         3: return ELAPSED_BITS_DEF'($urandom_range(5000, 1));
         4, 5: return ELAPSED_BITS_DEF'($urandom_range(60000, 40000));
         default: return ELAPSED_BITS_DEF'($urandom);
      endcase
   endfunction

   // Gain or speed word with random bits above the register's width.
   function automatic logic [CSR_DATA_BITS-1:0] gain_word(input int top);
      logic [CSR_DATA_BITS-1:0] w;
      w = CSR_DATA_BITS'($urandom_range(1023));
      w[GAIN_BITS-1:0] = GAIN_BITS'($urandom_range(top));
      return w;
   endfunction

   initial begin
      logic [DARK_BITS-1:0] ld;
      logic [DARK_BITS-1:0] rd;
      req_if.valid        = 1'b0;
      req_if.left_sample  = '0;
      req_if.right_sample = '0;
      req_if.elapsed_us   = '0;
      rsp_if.ready        = 1'b0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // ---- directed: moderate gains, both dark levels at mid-scale ----
      configure(10'd20, 10'd5, 10'd3, 10'd500, 10'd500, 10'd100);
      send_sample(SAMPLE_MAX, SAMPLE_MAX, 24'd1000);   // neither dark
      send_sample(SAMPLE_MAX, '0, 24'd1);              // right dark, shortest interval
      send_sample('0, SAMPLE_MAX, '0);                 // left dark, zero elapsed time
      send_sample('0, '0, ELAPSED_MAX);                // both dark, last seen left
      send_sample(SAMPLE_MAX, 10'd499, 24'd50000);     // right just under its level
      send_sample('0, '0, 24'd50000);                  // both dark, last seen right
      send_sample(10'd500, 10'd500, 24'd1);            // both exactly at level: not dark
      send_sample(10'd499, SAMPLE_MAX, 24'd2);         // left just under its level
      send_sample(SAMPLE_MAX, SAMPLE_MAX, ELAPSED_MAX);
      settle();

      // ---- directed: full-scale gains and levels; drive and speeds saturate ----
      configure('1, '1, '1, '1, '1, '1);
      send_sample(SAMPLE_MAX, '0, 24'd1);              // large positive drive
      send_sample('0, SAMPLE_MAX, 24'd1);              // large negative drive
      send_sample('0, '0, 24'd1);                      // both dark after left
      send_sample(SAMPLE_MAX, '0, '0);                 // swing to right, no derivative
      send_sample(10'd1022, 10'd1022, ELAPSED_MAX);    // both dark after right
      send_sample(SAMPLE_MAX, SAMPLE_MAX, 24'd1);      // back to zero, big derivative
      settle();

      // ---- directed: everything zero; nothing can read as dark ----
      configure('0, '0, '0, '0, '0, '0);
      send_sample('0, '0, 24'd1);
      send_sample(SAMPLE_MAX, SAMPLE_MAX, '0);

      // ---- random phases: new settings and a new idling mix each time ----
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         settle();
         if (p == 1) begin
            ld = '1;
            rd = '1;
            configure('1, '1, '1, ld, rd, '1);
         end else begin
            ld = DARK_BITS'($urandom_range(900, 100));
            rd = DARK_BITS'($urandom_range(900, 100));
            configure(gain_word(40), gain_word(40), gain_word(p == 0 ? 255 : 20),
                      ld, rd, gain_word(255));
         end
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
            default: begin send_idle_pct = 14; recv_stall_pct = 14; end
         endcase
         repeat (ITEMS_PER_PHASE)
            send_sample(pick_sample(ld), pick_sample(rd), pick_elapsed());
      end

      // drain, then give a late or spurious response time to show up
      settle();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (fail_count == 0 && pending == 0)
         $display("line_follow_pd_controller_tb: PASS");
      else
         $display("line_follow_pd_controller_tb: FAIL");
      $finish;
   end

endmodule

>>> files.f
rtl/lfpd_pkg.sv
rtl/lfpd_if.sv
rtl/lfpd_tape_error.sv
rtl/lfpd_serial_div.sv
rtl/lfpd_drive_unit.sv
rtl/line_follow_pd_controller.sv
bench/lfpd_steer_checker.sv
bench/line_follow_pd_controller_tb.sv
